// ===== rtl/core/utf8d_pkg.sv =====
// Shared types and constants for the strict UTF-8 decoder.
// No dependencies; imported by utf8d_step, utf8_strict_decoder and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package utf8d_pkg;

  typedef enum logic [2:0] {
    KIND_OK         = 3'd0,
    KIND_STRAY_CONT = 3'd1,
    KIND_BAD_LEAD   = 3'd2,
    KIND_TRUNCATED  = 3'd3,
    KIND_EXP_CONT   = 3'd4,
    KIND_OVERLONG   = 3'd5,
    KIND_SURROGATE  = 3'd6,
    KIND_ABOVE_MAX  = 3'd7
  } kind_t;

  localparam logic [20:0] CP_MAX        = 21'h10FFFF;
  localparam logic [20:0] SURROGATE_LO  = 21'h00D800;
  localparam logic [20:0] SURROGATE_HI  = 21'h00DFFF;

  // Sequence state that does not depend on the offset width
  typedef struct packed {
    logic [2:0]  expected_len;
    logic [2:0]  received_len;
    logic [20:0] accumulator;
    logic        mismatch_pending;
    logic [7:0]  mismatch_byte;
    logic        halted;
  } dec_state_t;

  // What one byte does to the offset registers and the result
  typedef struct packed {
    logic        emit;
    kind_t       kind;
    logic [20:0] code_point;
    logic [2:0]  seq_length;
    logic [7:0]  bad_byte;
    logic        eoff_lead;
    logic        latch_lead;
    logic        latch_mis;
    logic        clear;
  } dec_action_t;

  // Smallest scalar value that needs a sequence of the given length
  function automatic logic [20:0] min_for_len(input logic [2:0] n);
    logic [20:0] v;
    case (n)
      3'd2:    v = 21'h000080;
      3'd3:    v = 21'h000800;
      3'd4:    v = 21'h010000;
      default: v = 21'h000000;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/utf8d_step.sv =====
// Per-byte decode step: classifies one byte against the open sequence and
// produces the next sequence state and the result action. Uses utf8d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module utf8d_step (
  input  utf8d_pkg::dec_state_t  st,
  input  logic [7:0]             byte_value,
  input  logic                   final_byte,
  output utf8d_pkg::dec_state_t  st_nxt,
  output utf8d_pkg::dec_action_t act
);
  import utf8d_pkg::*;

  logic        cont;
  logic [2:0]  lead_n;
  logic [20:0] lead_bits;
  logic [2:0]  rcv;
  logic        pend_new;
  logic [7:0]  mbyte_new;
  logic [20:0] acc_new;

  assign cont = (byte_value[7:6] == 2'b10);

  always_comb begin
    if (byte_value[7] == 1'b0) begin
      lead_n    = 3'd1;
      lead_bits = {14'd0, byte_value[6:0]};
    end else if (byte_value[7:5] == 3'b110) begin
      lead_n    = 3'd2;
      lead_bits = {16'd0, byte_value[4:0]};
    end else if (byte_value[7:4] == 4'b1110) begin
      lead_n    = 3'd3;
      lead_bits = {17'd0, byte_value[3:0]};
    end else if (byte_value[7:3] == 5'b11110) begin
      lead_n    = 3'd4;
      lead_bits = {18'd0, byte_value[2:0]};
    end else begin
      lead_n    = 3'd0;
      lead_bits = 21'd0;
    end
  end

  assign rcv       = st.received_len + 3'd1;
  assign pend_new  = st.mismatch_pending | ~cont;
  assign mbyte_new = (!cont && !st.mismatch_pending) ? byte_value : st.mismatch_byte;
  assign acc_new   = cont ? {st.accumulator[14:0], byte_value[5:0]} : st.accumulator;

  always_comb begin
    st_nxt     = st;
    act        = '0;
    act.kind   = KIND_OK;
    act.clear  = final_byte;
    if (st.halted) begin
      act.emit = 1'b0;
    end else if (st.expected_len == 3'd0) begin
      if (lead_n == 3'd0) begin
        act.emit     = 1'b1;
        act.kind     = cont ? KIND_STRAY_CONT : KIND_BAD_LEAD;
        act.bad_byte = byte_value;
      end else if (lead_n == 3'd1) begin
        act.emit       = 1'b1;
        act.code_point = lead_bits;
        act.seq_length = 3'd1;
      end else if (final_byte) begin
        act.emit = 1'b1;
        act.kind = KIND_TRUNCATED;
      end else begin
        // open a new sequence at this offset
        st_nxt.expected_len     = lead_n;
        st_nxt.received_len     = 3'd1;
        st_nxt.accumulator      = lead_bits;
        st_nxt.mismatch_pending = 1'b0;
        st_nxt.mismatch_byte    = 8'd0;
        act.latch_lead          = 1'b1;
      end
    end else begin
      st_nxt.received_len     = rcv;
      st_nxt.mismatch_pending = pend_new;
      st_nxt.mismatch_byte    = mbyte_new;
      st_nxt.accumulator      = acc_new;
      act.latch_mis           = ~cont & ~st.mismatch_pending;
      if (rcv >= st.expected_len) begin
        st_nxt.expected_len     = 3'd0;
        st_nxt.mismatch_pending = 1'b0;
        act.emit                = 1'b1;
        act.eoff_lead           = 1'b1;
        if (pend_new) begin
          act.kind     = KIND_EXP_CONT;
          act.bad_byte = mbyte_new;
        end else if (acc_new < min_for_len(st.expected_len)) begin
          act.kind = KIND_OVERLONG;
        end else if (acc_new >= SURROGATE_LO && acc_new <= SURROGATE_HI) begin
          act.kind = KIND_SURROGATE;
        end else if (acc_new > CP_MAX) begin
          act.kind = KIND_ABOVE_MAX;
        end else begin
          act.code_point = acc_new;
          act.seq_length = st.expected_len;
        end
      end else if (final_byte) begin
        // truncation outranks a pending mismatch
        st_nxt.expected_len = 3'd0;
        act.emit            = 1'b1;
        act.kind            = KIND_TRUNCATED;
        act.eoff_lead       = 1'b1;
      end
    end

    if (final_byte) begin
      st_nxt = '0;
    end else if (act.emit && act.kind != KIND_OK) begin
      st_nxt.halted = 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/utf8_strict_decoder.sv =====
// Strict streaming UTF-8 decoder, top level: input register, decode step,
// offset counters and result register. Uses utf8d_pkg and utf8d_step.
// A byte goes from the input register through the decode step into the result register.
// Throughput: one byte per clock; while a result waits, the input register holds one
// more byte and in_ready drops until that result transfers.
// Reset (rst_n low, synchronous) clears both stages, the sequence state and offsets.
`timescale 1ns / 1ps
`default_nettype none

module utf8_strict_decoder #(
  parameter int OFFSET_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte_value,
  input  wire logic        in_final_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [20:0]      out_code_point,
  output logic [2:0]       out_seq_length,
  output logic [2:0]       out_error_kind,
  output logic [31:0]      out_error_offset,
  output logic [31:0]      out_bad_offset,
  output logic [7:0]       out_bad_byte,
  output logic             out_stream_end
);
  import utf8d_pkg::*;

  localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;
  localparam logic [OFFSET_BITS-1:0] POS_ONE = {{(OFFSET_BITS-1){1'b0}}, 1'b1};

  // input stage
  logic       s1_v_r;
  logic [7:0] s1_byte_r;
  logic       s1_fin_r;
  logic       s2_go;

  // sequence state
  dec_state_t  st_r;
  dec_state_t  st_nxt;
  dec_action_t act;

  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [OFFSET_BITS-1:0] lead_pos_r, lead_pos_nxt;
  logic [OFFSET_BITS-1:0] mis_pos_r, mis_pos_nxt;
  logic [OFFSET_BITS-1:0] eoff_w, boff_w, mis_pos_cur;
  logic [31:0]            eoff32, boff32;

  // result register
  logic        out_valid_r;
  logic [20:0] cp_r;
  logic [2:0]  len_r;
  logic [2:0]  kind_r;
  logic [31:0] eoff_r;
  logic [31:0] boff_r;
  logic [7:0]  bbyte_r;
  logic        end_r;

  assign s2_go    = s1_v_r & (~out_valid_r | out_ready);
  assign in_ready = ~s1_v_r | s2_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ready) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_byte_value;
      s1_fin_r  <= in_final_byte;
    end
  end

  utf8d_step u_step (
    .st         (st_r),
    .byte_value (s1_byte_r),
    .final_byte (s1_fin_r),
    .st_nxt     (st_nxt),
    .act        (act)
  );

  // offset of the current byte is pos_r; saturate the counter
  always_comb begin
    if (act.clear) begin
      pos_nxt      = '0;
      lead_pos_nxt = '0;
      mis_pos_nxt  = '0;
    end else begin
      pos_nxt      = (pos_r == POS_MAX) ? pos_r : pos_r + POS_ONE;
      lead_pos_nxt = act.latch_lead ? pos_r : lead_pos_r;
      mis_pos_nxt  = act.latch_mis ? pos_r : mis_pos_r;
    end
  end

  assign mis_pos_cur = act.latch_mis ? pos_r : mis_pos_r;
  assign eoff_w = (act.kind == KIND_OK) ? '0 : (act.eoff_lead ? lead_pos_r : pos_r);
  assign boff_w = (act.kind == KIND_EXP_CONT) ? mis_pos_cur : '0;

  generate
    if (OFFSET_BITS > 32) begin : g_clamp
      assign eoff32 = (|eoff_w[OFFSET_BITS-1:32]) ? 32'hFFFF_FFFF : eoff_w[31:0];
      assign boff32 = (|boff_w[OFFSET_BITS-1:32]) ? 32'hFFFF_FFFF : boff_w[31:0];
    end else begin : g_extend
      assign eoff32 = 32'(eoff_w);
      assign boff32 = 32'(boff_w);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= '0;
      pos_r      <= '0;
      lead_pos_r <= '0;
      mis_pos_r  <= '0;
    end else if (s2_go) begin
      st_r       <= st_nxt;
      pos_r      <= pos_nxt;
      lead_pos_r <= lead_pos_nxt;
      mis_pos_r  <= mis_pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_go) begin
      out_valid_r <= act.emit;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go && act.emit) begin
      cp_r    <= act.code_point;
      len_r   <= act.seq_length;
      kind_r  <= act.kind;
      eoff_r  <= eoff32;
      boff_r  <= boff32;
      bbyte_r <= act.bad_byte;
      end_r   <= s1_fin_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_code_point   = cp_r;
  assign out_seq_length   = len_r;
  assign out_error_kind   = kind_r;
  assign out_error_offset = eoff_r;
  assign out_bad_offset   = boff_r;
  assign out_bad_byte     = bbyte_r;
  assign out_stream_end   = end_r;

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for utf8_strict_decoder: a directed byte table, then random streams.
// Depends on utf8d_pkg and the decoder RTL; typed table rows give their own expected results,
// the rest come from a behavioral decoder that is stepped on every accepted input transfer.
`timescale 1ns / 1ps

module testbench;
  import utf8d_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int RANDOM_ITEMS = 1000;
  localparam int TAIL_CYCLES  = 20;

  typedef struct packed {
    logic [20:0] cp;
    logic [2:0]  len;
    kind_t       kind;
    logic [31:0] eoff;
    logic [31:0] boff;
    logic [7:0]  bbyte;
    logic        send;
  } decoded_t;

  typedef struct packed {
    logic [7:0] b;
    logic       fin;
    logic       typed;
    decoded_t   want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte_value = 8'h00;
  logic        in_final_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [20:0] out_code_point;
  logic [2:0]  out_seq_length;
  logic [2:0]  out_error_kind;
  logic [31:0] out_error_offset;
  logic [31:0] out_bad_offset;
  logic [7:0]  out_bad_byte;
  logic        out_stream_end;

  // Behavioral decoder state
  logic [31:0] stream_pos, lead_pos, mismatch_pos;
  logic [2:0]  seq_need, seq_have;
  logic [20:0] scalar_acc;
  logic        mismatch_seen, dropping;
  logic [7:0]  mismatch_val;

  decoded_t    pending_chars[$];
  stim_row_t   directed_rows[$];
  logic [7:0]  stream_bytes[$];
  int          failures = 0;
  int          live_items = 0;
  int          cycle_count = 0;
  int          stall_left = 0;
  int          steady_left = 0;

  utf8_strict_decoder i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte_value    (in_byte_value),
    .in_final_byte    (in_final_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_code_point   (out_code_point),
    .out_seq_length   (out_seq_length),
    .out_error_kind   (out_error_kind),
    .out_error_offset (out_error_offset),
    .out_bad_offset   (out_bad_offset),
    .out_bad_byte     (out_bad_byte),
    .out_stream_end   (out_stream_end)
  );

  always #2 clk = ~clk;

  function automatic logic [20:0] first_code(input int n);
    case (n)
      2:       return 21'h000080;
      3:       return 21'h000800;
      4:       return 21'h010000;
      default: return 21'h000000;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  // Append to the tail of each queue
  task automatic add_row(input stim_row_t row);
    directed_rows.insert(directed_rows.size(), row);
  endtask

  task automatic add_byte(input logic [7:0] v);
    stream_bytes.insert(stream_bytes.size(), v);
  endtask

  task automatic add_result(input decoded_t r);
    pending_chars.insert(pending_chars.size(), r);
  endtask

  task automatic clear_state();
    stream_pos    = '0;
    lead_pos      = '0;
    mismatch_pos  = '0;
    seq_need      = '0;
    seq_have      = '0;
    scalar_acc    = '0;
    mismatch_seen = 1'b0;
    mismatch_val  = '0;
    dropping      = 1'b0;
  endtask

  // Step the decoder by one byte; emit says whether a result comes out
  task automatic decode_byte(input logic [7:0] b, input logic fin,
                             output bit emit, output decoded_t r);
    logic [31:0] cur;
    int          n;
    logic [20:0] bits;
    logic        cont;
    cur    = stream_pos;
    r      = '0;
    r.kind = KIND_OK;
    emit   = 1'b0;
    n      = 0;
    bits   = '0;
    cont   = (b[7:6] == 2'b10);
    if (stream_pos != '1) stream_pos = stream_pos + 32'd1;

    if (dropping) begin
      if (fin) clear_state();
    end else if (seq_need == 0) begin
      if (b < 8'h80) begin
        n = 1; bits = {14'd0, b[6:0]};
      end else if (b[7:5] == 3'b110) begin
        n = 2; bits = {16'd0, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
        n = 3; bits = {17'd0, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
        n = 4; bits = {18'd0, b[2:0]};
      end
      if (n == 0) begin
        emit    = 1'b1;
        r.kind  = cont ? KIND_STRAY_CONT : KIND_BAD_LEAD;
        r.eoff  = cur;
        r.bbyte = b;
      end else if (n == 1) begin
        emit  = 1'b1;
        r.cp  = bits;
        r.len = 3'd1;
      end else if (fin) begin
        emit   = 1'b1;
        r.kind = KIND_TRUNCATED;
        r.eoff = cur;
      end else begin
        seq_need      = n[2:0];
        seq_have      = 3'd1;
        scalar_acc    = bits;
        lead_pos      = cur;
        mismatch_seen = 1'b0;
        mismatch_val  = '0;
        mismatch_pos  = '0;
      end
    end else begin
      seq_have = seq_have + 3'd1;
      // keep only the first non-continuation byte of the window
      if (!cont) begin
        if (!mismatch_seen) begin
          mismatch_seen = 1'b1;
          mismatch_val  = b;
          mismatch_pos  = cur;
        end
      end else begin
        scalar_acc = {scalar_acc[14:0], b[5:0]};
      end
      if (seq_have >= seq_need) begin
        emit     = 1'b1;
        n        = int'(seq_need);
        seq_need = '0;
        if (mismatch_seen) begin
          r.kind  = KIND_EXP_CONT;
          r.eoff  = lead_pos;
          r.boff  = mismatch_pos;
          r.bbyte = mismatch_val;
        end else if (scalar_acc < first_code(n)) begin
          r.kind = KIND_OVERLONG;
          r.eoff = lead_pos;
        end else if (scalar_acc >= SURROGATE_LO && scalar_acc <= SURROGATE_HI) begin
          r.kind = KIND_SURROGATE;
          r.eoff = lead_pos;
        end else if (scalar_acc > CP_MAX) begin
          r.kind = KIND_ABOVE_MAX;
          r.eoff = lead_pos;
        end else begin
          r.cp  = scalar_acc;
          r.len = n[2:0];
        end
        mismatch_seen = 1'b0;
      end else if (fin) begin
        // truncation outranks a pending mismatch
        seq_need = '0;
        emit     = 1'b1;
        r.kind   = KIND_TRUNCATED;
        r.eoff   = lead_pos;
      end
    end

    if (emit) begin
      r.send = fin;
      if (fin) clear_state();
      else if (r.kind != KIND_OK) dropping = 1'b1;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want_v);
    $display("%0t MISMATCH %s: got %0h, expected %0h", $time, what, got, want_v);
    failures++;
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want_v);
    if (got !== want_v) report_mismatch(what, got, want_v);
  endtask

  function automatic stim_row_t entry(input logic [7:0] b, input logic fin, input logic typed,
                                      input kind_t kind, input logic [20:0] cp,
                                      input logic [2:0] len, input logic [7:0] bad);
    stim_row_t row;
    row            = '0;
    row.b          = b;
    row.fin        = fin;
    row.typed      = typed;
    row.want.cp    = cp;
    row.want.len   = len;
    row.want.kind  = kind;
    row.want.bbyte = bad;
    row.want.send  = fin;
    return row;
  endfunction

  // Present one byte, hold it until the transfer, then step the decoder
  task automatic send_byte(input logic [7:0] b, input logic fin, input logic typed,
                           input decoded_t typed_want, input bit calm);
    bit       emit;
    decoded_t got;
    int       gap;
    in_valid      <= 1'b1;
    in_byte_value <= b;
    in_final_byte <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    live_items++;
    decode_byte(b, fin, emit, got);
    if (typed) add_result(typed_want);
    else if (emit) add_result(got);
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_chars.size() != 0) @(posedge clk);
  endtask

  task automatic push_seq(input logic [20:0] cp, input int n);
    case (n)
      1: add_byte({1'b0, cp[6:0]});
      2: begin
        add_byte({3'b110, cp[10:6]});
        add_byte({2'b10, cp[5:0]});
      end
      3: begin
        add_byte({4'b1110, cp[15:12]});
        add_byte({2'b10, cp[11:6]});
        add_byte({2'b10, cp[5:0]});
      end
      default: begin
        add_byte({5'b11110, cp[20:18]});
        add_byte({2'b10, cp[17:12]});
        add_byte({2'b10, cp[11:6]});
        add_byte({2'b10, cp[5:0]});
      end
    endcase
  endtask

  // Append one character: mostly well-formed, the rest broken in one way or another
  task automatic make_char();
    int          mode, n, start, cut;
    logic [20:0] cp, lo, hi;
    logic [7:0]  bad;
    mode = $urandom_range(0, 99);
    n    = (mode >= 75) ? $urandom_range(2, 4) : $urandom_range(1, 4);
    lo   = first_code(n);
    case (n)
      1:       hi = 21'h00007F;
      2:       hi = 21'h0007FF;
      3:       hi = 21'h00FFFF;
      default: hi = CP_MAX;
    endcase
    if ($urandom_range(0, 7) == 0) cp = $urandom_range(0, 1) ? hi : lo;
    else cp = 21'($urandom_range(hi, lo));
    if (n == 3 && cp >= SURROGATE_LO && cp <= SURROGATE_HI) cp = cp ^ 21'h002000;

    if (mode < 75) begin
    end else if (mode < 79) begin
      cp = 21'($urandom_range(lo - 1, 0));
    end else if (mode < 83) begin
      n  = 3;
      cp = 21'($urandom_range(SURROGATE_HI, SURROGATE_LO));
    end else if (mode < 87) begin
      n  = 4;
      cp = 21'($urandom_range(21'h1FFFFF, 21'h110000));
    end

    if (mode >= 95) begin
      add_byte(8'($urandom_range(0, 255)));
    end else begin
      start = stream_bytes.size();
      push_seq(cp, n);
      if (mode >= 87 && mode < 91) begin
        bad = 8'($urandom_range(0, 255));
        if (bad[7:6] == 2'b10) bad[6] = 1'b1;
        stream_bytes[start + $urandom_range(1, n - 1)] = bad;
      end else if (mode >= 91) begin
        cut = $urandom_range(1, n - 1);
        repeat (cut) stream_bytes.delete(stream_bytes.size() - 1);
      end
    end
  endtask

  // Receiver: random stalls with occasional steady stretches
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if (steady_left > 0) steady_left--;
      else if ($urandom_range(0, 49) == 0) steady_left = $urandom_range(20, 200);
      else stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin : check_results
    decoded_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_chars.size() == 0) begin
        report_mismatch("result with nothing expected, code_point",
                        32'(out_code_point), 32'd0);
      end else begin
        want = pending_chars.pop_front();
        check_field("code_point", 32'(out_code_point), 32'(want.cp));
        check_field("seq_length", 32'(out_seq_length), 32'(want.len));
        check_field("error_kind", 32'(out_error_kind), 32'(want.kind));
        check_field("error_offset", out_error_offset, want.eoff);
        check_field("bad_offset", out_bad_offset, want.boff);
        check_field("bad_byte", 32'(out_bad_byte), 32'(want.bbyte));
        check_field("stream_end", 32'(out_stream_end), 32'(want.send));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int  nchars, stream_no;
    bit  calm, close;
    clear_state();

    // singles, smallest two-byte scalar, largest scalar, overlong two-byte form, then drop to the final byte
    add_row(entry(8'h00, 1'b0, 1'b1, KIND_OK, 21'h000000, 3'd1, 8'h00));
    add_row(entry(8'h7F, 1'b0, 1'b1, KIND_OK, 21'h00007F, 3'd1, 8'h00));
    add_row(entry(8'hC2, 1'b0, 1'b0, KIND_OK, 21'd0, 3'd0, 8'h00));
    add_row(entry(8'h80, 1'b0, 1'b0, KIND_OK, 21'd0, 3'd0, 8'h00));
    add_row(entry(8'hF4, 1'b0, 1'b0, KIND_OK, 21'd0, 3'd0, 8'h00));
    add_row(entry(8'h8F, 1'b0, 1'b0, KIND_OK, 21'd0, 3'd0, 8'h00));
    add_row(entry(8'hBF, 1'b0, 1'b0, KIND_OK, 21'd0, 3'd0, 8'h00));
    add_row(entry(8'hBF, 1'b0, 1'b0, KIND_OK, 21'd0, 3'd0, 8'h00));
    add_row(entry(8'hC0, 1'b0, 1'b0, KIND_OK, 21'd0, 3'd0, 8'h00));
    add_row(entry(8'h80, 1'b0, 1'b0, KIND_OK, 21'd0, 3'd0, 8'h00));
    add_row(entry(8'h41, 1'b1, 1'b0, KIND_OK, 21'd0, 3'd0, 8'h00));
    // stray continuation, rearm, then a bad lead that closes its stream
    add_row(entry(8'h80, 1'b0, 1'b1, KIND_STRAY_CONT, 21'd0, 3'd0, 8'h80));
    add_row(entry(8'h00, 1'b1, 1'b0, KIND_OK, 21'd0, 3'd0, 8'h00));
    add_row(entry(8'hFF, 1'b1, 1'b1, KIND_BAD_LEAD, 21'd0, 3'd0, 8'hFF));
    // surrogate, multi-byte lead on the final byte, above the top scalar
    add_row(entry(8'hED, 1'b0, 1'b0, KIND_OK, 21'd0, 3'd0, 8'h00));
    add_row(entry(8'hA0, 1'b0, 1'b0, KIND_OK, 21'd0, 3'd0, 8'h00));
    add_row(entry(8'h80, 1'b1, 1'b0, KIND_OK, 21'd0, 3'd0, 8'h00));
    add_row(entry(8'hF0, 1'b1, 1'b1, KIND_TRUNCATED, 21'd0, 3'd0, 8'h00));
    add_row(entry(8'hF5, 1'b0, 1'b0, KIND_OK, 21'd0, 3'd0, 8'h00));
    add_row(entry(8'h80, 1'b0, 1'b0, KIND_OK, 21'd0, 3'd0, 8'h00));
    add_row(entry(8'h80, 1'b0, 1'b0, KIND_OK, 21'd0, 3'd0, 8'h00));
    add_row(entry(8'h80, 1'b1, 1'b0, KIND_OK, 21'd0, 3'd0, 8'h00));
    // mismatch reported at window end; truncation wins over a pending mismatch
    add_row(entry(8'hE2, 1'b0, 1'b0, KIND_OK, 21'd0, 3'd0, 8'h00));
    add_row(entry(8'h41, 1'b0, 1'b0, KIND_OK, 21'd0, 3'd0, 8'h00));
    add_row(entry(8'h80, 1'b1, 1'b0, KIND_OK, 21'd0, 3'd0, 8'h00));
    add_row(entry(8'hF0, 1'b0, 1'b0, KIND_OK, 21'd0, 3'd0, 8'h00));
    add_row(entry(8'h41, 1'b0, 1'b0, KIND_OK, 21'd0, 3'd0, 8'h00));
    add_row(entry(8'h80, 1'b1, 1'b0, KIND_OK, 21'd0, 3'd0, 8'h00));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_byte(directed_rows[i].b, directed_rows[i].fin, directed_rows[i].typed,
                directed_rows[i].want, 1'b0);
    drain_results();

    live_items = 0;
    stream_no  = 0;
    while (live_items < RANDOM_ITEMS) begin
      stream_bytes.delete();
      nchars = $urandom_range(1, 10);
      repeat (nchars) make_char();
      calm  = ($urandom_range(0, 3) == 0);
      close = ($urandom_range(0, 9) != 0);
      foreach (stream_bytes[i])
        send_byte(stream_bytes[i], close && (i == stream_bytes.size() - 1), 1'b0, '0, calm);
      stream_no++;
      // hold off the sender until the pipeline is empty
      if (stream_no % 20 == 0) drain_results();
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
